// ===== hdl/rgpg_pkg.sv =====
// Package for the RGB gamma / pedestal / gain corrector.
// Holds register indexes, special-case codes and constant-table builders.
`timescale 1ns / 1ps
`default_nettype none
package rgpg_pkg;

  localparam int RegWidth = 48;
  localparam int LaneWidth = 16;
  localparam int IndexWidth = 8;
  localparam int ExpShift = 9;

  localparam logic [IndexWidth-1:0] REG_INV_GAMMA = 8'd0;
  localparam logic [IndexWidth-1:0] REG_BLACK_STRETCH = 8'd1;
  localparam logic [IndexWidth-1:0] REG_PEDESTAL = 8'd2;
  localparam logic [IndexWidth-1:0] REG_GAIN = 8'd3;

  localparam logic [RegWidth-1:0] INV_GAMMA_RESET = 48'h020002000200;
  localparam logic [RegWidth-1:0] UNITY_RESET = 48'h100010001000;
  localparam logic [RegWidth-1:0] PEDESTAL_RESET = 48'h000000000000;

  typedef enum logic [1:0] {
    G_NORMAL,
    G_ONE,
    G_ZERO
  } gcode_t;

  // log2 of v in Q.fb, mantissa squared in Q1.30
  function automatic logic [63:0] lg2(input logic [63:0] v, input int fb);
    logic [63:0] m;
    logic [63:0] frac;
    int ip;
    ip = 0;
    for (int i = 0; i < 62; i++) begin
      if ((v >> (i + 1)) != 64'd0) ip = i + 1;
    end
    m = v << (30 - ip);
    frac = 64'd0;
    for (int k = 0; k < fb; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(ip) << fb) | frac;
  endfunction

  function automatic logic [63:0] dval(input int level, input int cb, input int fb);
    logic [63:0] lm;
    logic [63:0] lx;
    lm = lg2((64'd1 << cb) - 64'd1, fb);
    lx = lg2(64'(level), fb);
    return (lm > lx) ? (lm - lx) : 64'd0;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] b;
    a = a_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > a) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (a >= r + b) begin
          a = a - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^-(2^-k) in Q.30
  function automatic logic [63:0] cval(input int k);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int j = 1; j <= k; j++) begin
      c = isqrt(c << 30);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rgb_gamma_pedestal_gain.sv =====
// Top level: config registers, three channel lanes and the result strobe pipeline.
// Depends on rgpg_pkg and rgpg_lane.
`timescale 1ns / 1ps
`default_nettype none
// Corrects one RGB pixel per clock: each channel is raised to its inverse gamma,
// scaled by black stretch, offset by half the pedestal, scaled by gain and
// clamped. busy stays low, so a pixel may be started every cycle. The result
// appears on red_out/green_out/blue_out with done high for one cycle; the
// pipeline depth is set by one exp2 stage per fraction bit. The receiver
// cannot stall. Registers are written through the cfg port (always ready) and
// must only change while no pixel is in flight.
module rgb_gamma_pedestal_gain import rgpg_pkg::*; #(
  parameter int CHANNEL_BITS = 8,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [CHANNEL_BITS-1:0] red_in,
  input  wire logic [CHANNEL_BITS-1:0] green_in,
  input  wire logic [CHANNEL_BITS-1:0] blue_in,
  output logic                         done,
  output logic [CHANNEL_BITS-1:0]      red_out,
  output logic [CHANNEL_BITS-1:0]      green_out,
  output logic [CHANNEL_BITS-1:0]      blue_out,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [IndexWidth-1:0]   cfg_index,
  input  wire logic [RegWidth-1:0]     cfg_data
);

  localparam int Latency = FRACTION_BITS + 7;

  logic [RegWidth-1:0] inv_gamma;
  logic [RegWidth-1:0] black_stretch;
  logic [RegWidth-1:0] pedestal;
  logic [RegWidth-1:0] gain;
  logic [Latency-1:0]  vpipe;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign done = vpipe[Latency-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_gamma <= INV_GAMMA_RESET;
      black_stretch <= UNITY_RESET;
      pedestal <= PEDESTAL_RESET;
      gain <= UNITY_RESET;
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[Latency-2:0], start & ~busy};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INV_GAMMA:     inv_gamma <= cfg_data;
          REG_BLACK_STRETCH: black_stretch <= cfg_data;
          REG_PEDESTAL:      pedestal <= cfg_data;
          REG_GAIN:          gain <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  logic [CHANNEL_BITS-1:0] lvl_in  [3];
  logic [CHANNEL_BITS-1:0] lvl_out [3];

  assign lvl_in[0] = red_in;
  assign lvl_in[1] = green_in;
  assign lvl_in[2] = blue_in;
  assign red_out = lvl_out[0];
  assign green_out = lvl_out[1];
  assign blue_out = lvl_out[2];

  genvar ch;
  generate
    for (ch = 0; ch < 3; ch++) begin : g_lane
      rgpg_lane #(
        .CHANNEL_BITS(CHANNEL_BITS),
        .FRACTION_BITS(FRACTION_BITS)
      ) u_lane (
        .clk(clk),
        .level(lvl_in[ch]),
        .inv_gamma(inv_gamma[ch*LaneWidth +: LaneWidth]),
        .black_stretch($signed(black_stretch[ch*LaneWidth +: LaneWidth])),
        .pedestal($signed(pedestal[ch*LaneWidth +: LaneWidth])),
        .gain($signed(gain[ch*LaneWidth +: LaneWidth])),
        .level_out(lvl_out[ch])
      );
    end
  endgenerate

endmodule
`default_nettype wire

// ===== hdl/rgpg_lane.sv =====
// One color channel: log table, exponent multiply, exp2 stages, stretch/pedestal/gain.
// Depends on rgpg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rgpg_lane import rgpg_pkg::*; #(
  parameter int CHANNEL_BITS = 8,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic [CHANNEL_BITS-1:0]  level,
  input  wire logic [LaneWidth-1:0]     inv_gamma,
  input  wire logic signed [LaneWidth-1:0] black_stretch,
  input  wire logic signed [LaneWidth-1:0] pedestal,
  input  wire logic signed [LaneWidth-1:0] gain,
  output logic [CHANNEL_BITS-1:0]       level_out
);

  localparam int CB = CHANNEL_BITS;
  localparam int F = FRACTION_BITS;
  localparam int Levels = 2 ** CB;
  localparam int DW = CB + F;
  localparam int PRW = LaneWidth + DW;
  localparam int TW = PRW - ExpShift;
  localparam int NW = TW - F;
  localparam int RW = 31;
  localparam int GW = F + 1;
  localparam int SW = F + 18;
  localparam int WW = F + 34;
  localparam int PW = F + 24 + CB;

  logic [DW-1:0] dtab [Levels];

  genvar gi;
  generate
    for (gi = 0; gi < Levels; gi++) begin : g_dtab
      localparam logic [63:0] DV = dval(gi, CB, F);
      assign dtab[gi] = DV[DW-1:0];
    end
  endgenerate

  logic [CB-1:0] lev;
  logic [DW-1:0] d;
  logic          zero1;
  logic [TW-1:0] t;
  logic          zero2;
  logic [PRW-1:0] prod;

  always_ff @(posedge clk) begin
    lev <= level;
    d <= dtab[lev];
    zero1 <= (lev == '0);
    t <= prod[PRW-1:ExpShift];
    zero2 <= zero1;
  end

  assign prod = PRW'(inv_gamma) * PRW'(d);

  logic [RW-1:0] rr [F+1];
  logic [F-1:0]  ff [F+1];
  logic [4:0]    sh [F+1];
  gcode_t        gc [F+1];

  logic [NW-1:0] n;
  assign n = t[TW-1:F];

  always_comb begin
    rr[0] = RW'(1) << 30;
    ff[0] = t[F-1:0];
    sh[0] = 5'(30 - F) + 5'(n);
    if (inv_gamma == '0) begin
      gc[0] = G_ONE;
    end else if (zero2 || (n >= NW'(F + 1))) begin
      gc[0] = G_ZERO;
    end else begin
      gc[0] = G_NORMAL;
    end
  end

  generate
    for (gi = 1; gi <= F; gi++) begin : g_exp
      localparam logic [63:0] CV = cval(gi);
      logic [61:0] mp;
      assign mp = 62'(rr[gi-1]) * 62'(CV[30:0]);
      always_ff @(posedge clk) begin
        rr[gi] <= ff[gi-1][F-gi] ? mp[30+RW-1:30] : rr[gi-1];
        ff[gi] <= ff[gi-1];
        sh[gi] <= sh[gi-1];
        gc[gi] <= gc[gi-1];
      end
    end
  endgenerate

  logic [GW-1:0] g;
  logic [RW-1:0] rs;
  assign rs = rr[F] >> sh[F];

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] gx;
  logic signed [SW-1:0] bx;
  logic signed [SW-1:0] px;
  logic signed [WW-1:0] w;
  logic signed [WW-1:0] wx;
  logic [PW-1:0] pw;

  assign gx = SW'($signed({1'b0, g}));
  assign bx = SW'(black_stretch);
  assign px = SW'(pedestal) <<< (F - 1);
  assign wx = WW'(sum) * WW'(gain);
  assign pw = (PW'(w[F+23:0]) << CB) - PW'(w[F+23:0]);

  always_ff @(posedge clk) begin
    case (gc[F])
      G_ONE:  g <= GW'(1) << F;
      G_ZERO: g <= '0;
      default: g <= rs[GW-1:0];
    endcase
    sum <= gx * bx + px;
    w <= wx;
    if (w <= 0) begin
      level_out <= '0;
    end else if (w >= (WW'(1) <<< (F + 24))) begin
      level_out <= '1;
    end else begin
      level_out <= pw[PW-1 -: CB];
    end
  end

endmodule
`default_nettype wire
